### rtl/core/lfre_pkg.sv
// lfre_pkg: shared types and constants of the lamp fade ramp engine
// channel table entry, control states, field widths, beat layouts
// no dependencies
package lfre_pkg;

  // field and state widths
  localparam int LEVEL_BITS    = 12;
  localparam int FRACTION_BITS = 8;
  localparam int ACC_BITS      = LEVEL_BITS + FRACTION_BITS;
  localparam int SPEED_BITS    = 4;
  localparam int DELAY_BITS    = 8;
  localparam int CHAN_BITS     = 3;

  // speed codes
  localparam logic [SPEED_BITS-1:0] SPEED_JUMP = 4'd0;
  localparam logic [SPEED_BITS-1:0] SPEED_STOP = 4'd15;

  // 0.1 in fixed point, rounded to the nearest fraction lsb
  localparam int TENTH = ((1 << FRACTION_BITS) + 5) / 10;

  // divider sizing: numerator is (level+1) << FRACTION_BITS, two quotient bits a cycle
  localparam int NUM_BITS     = LEVEL_BITS + 1 + FRACTION_BITS;
  localparam int DIV_STEPS    = (NUM_BITS + 1) / 2;
  localparam int NUM_PAD      = 2 * DIV_STEPS;
  localparam int COUNT_BITS   = $clog2(DIV_STEPS);
  localparam int DIVISOR_BITS = 2 * SPEED_BITS;
  localparam int STEP_BITS    = NUM_BITS;

  // input tdata layout, lowest bit first
  localparam int IN_CHAN_LSB   = 0;
  localparam int IN_TARGET_LSB = IN_CHAN_LSB + CHAN_BITS;
  localparam int IN_SPEED_LSB  = IN_TARGET_LSB + LEVEL_BITS;
  localparam int IN_DELAY_LSB  = IN_SPEED_LSB + SPEED_BITS;
  localparam int IN_FORCE_BIT  = IN_DELAY_LSB + DELAY_BITS;
  localparam int IN_FORCED_LSB = IN_FORCE_BIT + 1;
  localparam int IN_DATA_BITS  = 40;

  // output tdata layout, lowest bit first
  localparam int OUT_CHAN_LSB  = 0;
  localparam int OUT_LEVEL_LSB = OUT_CHAN_LSB + CHAN_BITS;
  localparam int OUT_RAMP_BIT  = OUT_LEVEL_LSB + LEVEL_BITS;
  localparam int OUT_BUSY_BIT  = OUT_RAMP_BIT + 1;
  localparam int OUT_PAD_BITS  = 7;
  localparam int OUT_DATA_BITS = 24;

  // item kinds carried on tuser
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_PROGRAM = 1'b1;

  // one channel table entry; the level is the integer part of acc
  typedef struct packed {
    logic [ACC_BITS-1:0]   acc;
    logic [LEVEL_BITS-1:0] target;
    logic [SPEED_BITS-1:0] speed;
    logic [DELAY_BITS-1:0] delay;
  } chan_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIVIDE,
    ST_STEP,
    ST_FINISH
  } state_t;

endpackage

### rtl/core/lfre_ram.sv
// lfre_ram: generic single write port, single read port ram with registered read
// no dependencies
module lfre_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 6
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/lamp_fade_ramp_engine_unit.sv
// lamp_fade_ramp_engine_unit: dimmer channel table with per-channel fade ramps
// depends on lfre_pkg and lfre_ram
// a beat passes ST_READ and ST_FINISH; a ramp step also passes ST_DIVIDE and ST_STEP;
//   ST_FINISH waits for a free output register, and a new beat is taken only in ST_IDLE;
//   the ramp step is set by the 2-bit-per-cycle divider over a 21-bit numerator
// reset: rst clears control and the per-channel valid bits; unwritten channels read as zero
module lamp_fade_ramp_engine_unit #(
  parameter int CHANNELS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave side
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // channel, target_level, ramp_speed, start_delay, force_level, forced_value
  input  logic [lfre_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // kind
  input  logic                               s_tuser,
  // master side
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_channel, level, ramping, busy_res, zero pad
  output logic [lfre_pkg::OUT_DATA_BITS-1:0] m_tdata
);

  localparam int ADDR_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_BITS = $bits(lfre_pkg::chan_entry_t);
  localparam logic [6:0] CH_COUNT = 7'(CHANNELS);

  lfre_pkg::state_t state, state_next;

  // item registers
  logic                                   item_kind;
  logic [lfre_pkg::CHAN_BITS-1:0]         item_channel;
  logic                                   item_in_range;
  logic [lfre_pkg::LEVEL_BITS-1:0]        item_target;
  logic [lfre_pkg::SPEED_BITS-1:0]        item_speed;
  logic [lfre_pkg::DELAY_BITS-1:0]        item_delay;
  logic                                   item_force;
  logic [lfre_pkg::LEVEL_BITS-1:0]        item_forced;

  // working copy of the entry and result flags
  logic [lfre_pkg::ACC_BITS-1:0]          w_acc;
  logic [lfre_pkg::LEVEL_BITS-1:0]        w_target;
  logic [lfre_pkg::SPEED_BITS-1:0]        w_speed;
  logic [lfre_pkg::DELAY_BITS-1:0]        w_delay;
  logic                                   res_ramp;
  logic                                   res_busy;
  logic                                   ramp_pending;
  logic                                   rising;
  logic                                   do_write;

  // outcome of the table read
  logic [lfre_pkg::ACC_BITS-1:0]          w_acc_next;
  logic [lfre_pkg::LEVEL_BITS-1:0]        w_target_next;
  logic [lfre_pkg::SPEED_BITS-1:0]        w_speed_next;
  logic [lfre_pkg::DELAY_BITS-1:0]        w_delay_next;
  logic                                   res_ramp_next;
  logic                                   res_busy_next;
  logic                                   ramp_pending_next;

  // divider
  logic [lfre_pkg::DIVISOR_BITS-1:0]      divisor;
  logic [lfre_pkg::DIVISOR_BITS-1:0]      rem;
  logic [lfre_pkg::NUM_PAD-1:0]           num;
  logic [lfre_pkg::NUM_PAD-1:0]           quo;
  logic [lfre_pkg::COUNT_BITS-1:0]        div_count;
  logic [lfre_pkg::STEP_BITS-1:0]         step;

  // memory and valid bits
  logic [CHANNELS-1:0]                    entry_valid;
  logic                                   ram_we;
  logic [ADDR_BITS-1:0]                   ram_wr_addr;
  logic [ENTRY_BITS-1:0]                  ram_wr_data;
  logic                                   ram_rd_en;
  logic [ADDR_BITS-1:0]                   ram_rd_addr;
  logic [ENTRY_BITS-1:0]                  ram_rd_data;
  lfre_pkg::chan_entry_t                  entry;
  logic [lfre_pkg::LEVEL_BITS-1:0]        entry_level;

  logic                                   accept;
  logic                                   out_load;

  // divider step signals
  logic [lfre_pkg::DIVISOR_BITS:0]        r9a, r9b;
  logic                                   qa, qb;
  logic [lfre_pkg::DIVISOR_BITS-1:0]      ra, rb;

  // ramp finish signals
  logic [lfre_pkg::ACC_BITS+1:0]          rise_sum;
  logic [lfre_pkg::STEP_BITS-1:0]         fall_diff;
  logic [lfre_pkg::ACC_BITS-1:0]          fall_acc;
  logic [lfre_pkg::ACC_BITS-1:0]          clamp_acc;
  logic [lfre_pkg::ACC_BITS-1:0]          final_acc;

  lfre_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CHANNELS)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign accept      = s_tvalid && s_tready;
  assign ram_rd_en   = accept;
  assign ram_rd_addr = ADDR_BITS'(s_tdata[lfre_pkg::IN_CHAN_LSB +: lfre_pkg::CHAN_BITS]);
  assign ram_wr_addr = ADDR_BITS'(item_channel);
  assign ram_wr_data = {final_acc, w_target, w_speed, w_delay};

  // an entry never written reads as its reset value of zero
  assign entry       = entry_valid[ram_wr_addr] ? lfre_pkg::chan_entry_t'(ram_rd_data)
                                                : '0;
  assign entry_level = entry.acc[lfre_pkg::ACC_BITS-1:lfre_pkg::FRACTION_BITS];

  // decide what the item does to the entry once it has been read
  always_comb begin
    w_acc_next        = entry.acc;
    w_target_next     = entry.target;
    w_speed_next      = entry.speed;
    w_delay_next      = entry.delay;
    res_ramp_next     = 1'b0;
    res_busy_next     = 1'b0;
    ramp_pending_next = 1'b0;
    if (!item_in_range) begin
      // out of range channel reports level zero and touches nothing
      w_acc_next = '0;
    end else if (item_kind == lfre_pkg::KIND_PROGRAM) begin
      w_target_next = item_target;
      w_speed_next  = item_speed;
      w_delay_next  = item_delay;
      if (item_force) begin
        w_acc_next = {item_forced, lfre_pkg::FRACTION_BITS'(0)};
      end
    end else if (entry_level == entry.target) begin
      // at target, nothing moves
    end else if (entry.delay != '0) begin
      w_delay_next  = entry.delay - 1'b1;
      res_busy_next = 1'b1;
    end else if (entry.speed == lfre_pkg::SPEED_JUMP) begin
      w_acc_next = {entry.target, lfre_pkg::FRACTION_BITS'(0)};
    end else if (entry.speed == lfre_pkg::SPEED_STOP) begin
      w_target_next = entry_level;
    end else begin
      res_ramp_next     = 1'b1;
      res_busy_next     = 1'b1;
      ramp_pending_next = 1'b1;
    end
  end

  // two restoring division steps a cycle, remainder stays below the divisor
  always_comb begin
    r9a = {rem, num[lfre_pkg::NUM_PAD-1]};
    qa  = (r9a >= {1'b0, divisor});
    ra  = qa ? lfre_pkg::DIVISOR_BITS'(r9a - {1'b0, divisor})
             : r9a[lfre_pkg::DIVISOR_BITS-1:0];
    r9b = {ra, num[lfre_pkg::NUM_PAD-2]};
    qb  = (r9b >= {1'b0, divisor});
    rb  = qb ? lfre_pkg::DIVISOR_BITS'(r9b - {1'b0, divisor})
             : r9b[lfre_pkg::DIVISOR_BITS-1:0];
  end

  // apply the ramp step: clamp at the target both ways, floor at zero when falling
  always_comb begin
    clamp_acc = {w_target, lfre_pkg::FRACTION_BITS'(0)};
    rise_sum  = {2'b00, w_acc} + {1'b0, step};
    fall_diff = {1'b0, w_acc} - step;
    fall_acc  = ({1'b0, w_acc} > step) ? fall_diff[lfre_pkg::ACC_BITS-1:0] : '0;
    final_acc = w_acc;
    if (ramp_pending) begin
      if (rising) begin
        if (rise_sum[lfre_pkg::ACC_BITS+1:lfre_pkg::FRACTION_BITS] > {2'b00, w_target}) begin
          final_acc = clamp_acc;
        end else begin
          final_acc = rise_sum[lfre_pkg::ACC_BITS-1:0];
        end
      end else begin
        if (fall_acc[lfre_pkg::ACC_BITS-1:lfre_pkg::FRACTION_BITS] < w_target) begin
          final_acc = clamp_acc;
        end else begin
          final_acc = fall_acc;
        end
      end
    end
  end

  // control state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfre_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control outputs
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    case (state)
      lfre_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = lfre_pkg::ST_READ;
        end
      end
      lfre_pkg::ST_READ: begin
        // a tick that must move along a ramp goes through the divider
        if (ramp_pending_next) begin
          state_next = lfre_pkg::ST_DIVIDE;
        end else begin
          state_next = lfre_pkg::ST_FINISH;
        end
      end
      lfre_pkg::ST_DIVIDE: begin
        if (div_count == lfre_pkg::COUNT_BITS'(lfre_pkg::DIV_STEPS - 1)) begin
          state_next = lfre_pkg::ST_STEP;
        end
      end
      lfre_pkg::ST_STEP: begin
        state_next = lfre_pkg::ST_FINISH;
      end
      lfre_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          ram_we     = do_write;
          state_next = lfre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lfre_pkg::ST_IDLE;
      end
    endcase
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind     <= s_tuser;
      item_channel  <= s_tdata[lfre_pkg::IN_CHAN_LSB +: lfre_pkg::CHAN_BITS];
      item_in_range <= ({4'b0000, s_tdata[lfre_pkg::IN_CHAN_LSB +: lfre_pkg::CHAN_BITS]}
                        < CH_COUNT);
      item_target   <= s_tdata[lfre_pkg::IN_TARGET_LSB +: lfre_pkg::LEVEL_BITS];
      item_speed    <= s_tdata[lfre_pkg::IN_SPEED_LSB +: lfre_pkg::SPEED_BITS];
      item_delay    <= s_tdata[lfre_pkg::IN_DELAY_LSB +: lfre_pkg::DELAY_BITS];
      item_force    <= s_tdata[lfre_pkg::IN_FORCE_BIT];
      item_forced   <= s_tdata[lfre_pkg::IN_FORCED_LSB +: lfre_pkg::LEVEL_BITS];
    end
  end

  // entry update and divider datapath
  always_ff @(posedge clk) begin
    case (state)
      lfre_pkg::ST_READ: begin
        w_acc        <= w_acc_next;
        w_target     <= w_target_next;
        w_speed      <= w_speed_next;
        w_delay      <= w_delay_next;
        res_ramp     <= res_ramp_next;
        res_busy     <= res_busy_next;
        ramp_pending <= ramp_pending_next;
        do_write     <= item_in_range;
        rising       <= (entry_level < entry.target);
        divisor      <= entry.speed * entry.speed;
        rem          <= '0;
        quo          <= '0;
        div_count    <= '0;
        num          <= lfre_pkg::NUM_PAD'({({1'b0, entry_level} + 13'd1),
                                            lfre_pkg::FRACTION_BITS'(0)});
      end
      lfre_pkg::ST_DIVIDE: begin
        rem       <= rb;
        num       <= {num[lfre_pkg::NUM_PAD-3:0], 2'b00};
        quo       <= {quo[lfre_pkg::NUM_PAD-3:0], qa, qb};
        div_count <= div_count + 1'b1;
      end
      lfre_pkg::ST_STEP: begin
        step <= quo[lfre_pkg::STEP_BITS-1:0]
                + lfre_pkg::STEP_BITS'(lfre_pkg::TENTH);
      end
      default: begin
      end
    endcase
  end

  // per-channel valid bits stand in for clearing the table
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[ram_wr_addr] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {lfre_pkg::OUT_PAD_BITS'(0), res_busy, res_ramp,
                  final_acc[lfre_pkg::ACC_BITS-1:lfre_pkg::FRACTION_BITS], item_channel};
    end
  end

`ifndef SYNTHESIS
  // a table write always comes with a result beat
  a_write_gives_beat: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> m_tvalid)
    else $error("table written without a result beat");

  // only one item in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second item accepted while one is in flight");

  // divider count stays within its steps
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == lfre_pkg::ST_DIVIDE)
      |-> (div_count < lfre_pkg::COUNT_BITS'(lfre_pkg::DIV_STEPS)))
    else $error("divider ran past its last step");

  // a ramp step always reports busy
  a_ramp_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[lfre_pkg::OUT_RAMP_BIT] || m_tdata[lfre_pkg::OUT_BUSY_BIT]))
    else $error("ramping without busy");

  // the divider is only entered for a ramping tick
  a_divide_ramp: assert property (@(posedge clk) disable iff (rst)
    (state == lfre_pkg::ST_DIVIDE) |-> (ramp_pending && do_write))
    else $error("divider running without a ramp step");
`endif

endmodule
